### src/lab_pkg.sv
package lab_pkg;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    // s1 abs/max, s2 encode, s3 shift, s4 square, s5 sum, sqrt, prep, divide, final
    localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam logic [15:0] Q_ONE = 16'd16384;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } vec33_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec16_t;

    // Q4.28 to Q2.14, half away from zero, saturated to one
    function automatic logic signed [15:0] rnd_q28(input logic signed [33:0] p);
        logic [33:0] mag;
        logic [33:0] r;
        logic [15:0] c;
        mag = p[33] ? 34'(-p) : 34'(p);
        r   = (mag + 34'd8192) >> 14;
        c   = (r > 34'(Q_ONE)) ? Q_ONE : r[15:0];
        return p[33] ? 16'(-c) : c;
    endfunction

endpackage

### src/lab_norm.sv
module lab_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lab_pkg::vec33_t in_vec,
    output logic            out_valid,
    output lab_pkg::vec16_t out_vec,
    output logic            out_ok
);

    typedef struct packed {
        logic [2:0][29:0] mag;
        logic [2:0]       neg;
        logic             ok;
    } side_t;

    typedef struct packed {
        logic [61:0] n;
        logic [62:0] r;
        side_t       sd;
    } sq_t;

    typedef struct packed {
        logic [2:0][44:0] rem;
        logic [2:0][14:0] q;
        logic [30:0]      den;
        logic [2:0]       neg;
        logic             ok;
    } dv_t;

    // stage 1: magnitudes and maximum
    logic [2:0][32:0] a_reg;
    logic [2:0]       n1_reg;
    logic [32:0]      m_reg;
    logic             v1_reg;
    // stage 2: msb position
    logic [2:0][32:0] a2_reg;
    logic [2:0]       n2_reg;
    logic [5:0]       msb_reg;
    logic             ok2_reg;
    logic             v2_reg;
    // stage 3..5
    side_t            sd3_reg, sd4_reg, sd5_reg;
    logic [2:0][59:0] sq4_reg;
    logic [61:0]      sum5_reg;
    logic             v3_reg, v4_reg, v5_reg;

    logic [2:0][32:0] a_next;
    logic [32:0]      m_next;
    logic [5:0]       msb_next;
    logic [2:0][29:0] sh_next;

    always_comb
    begin
        a_next[0] = in_vec.x[32] ? 33'(-in_vec.x) : 33'(in_vec.x);
        a_next[1] = in_vec.y[32] ? 33'(-in_vec.y) : 33'(in_vec.y);
        a_next[2] = in_vec.z[32] ? 33'(-in_vec.z) : 33'(in_vec.z);
        m_next = a_next[0];
        if (a_next[1] > m_next)
            m_next = a_next[1];
        if (a_next[2] > m_next)
            m_next = a_next[2];
    end

    always_comb
    begin
        msb_next = 6'd0;
        for (int j = 0; j < 33; j++)
            if (m_reg[j])
                msb_next = 6'(j);
    end

    always_comb
    begin
        logic [32:0] t;
        for (int i = 0; i < 3; i++)
        begin
            if (msb_reg > 6'd29)
                t = a2_reg[i] >> (msb_reg - 6'd29);
            else
                t = a2_reg[i] << (6'd29 - msb_reg);
            sh_next[i] = t[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            n1_reg   <= {in_vec.z[32], in_vec.y[32], in_vec.x[32]};
            m_reg    <= m_next;
            a2_reg   <= a_reg;
            n2_reg   <= n1_reg;
            msb_reg  <= msb_next;
            ok2_reg  <= (m_reg != 33'd0);
            sd3_reg.mag <= sh_next;
            sd3_reg.neg <= n2_reg;
            sd3_reg.ok  <= ok2_reg;
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= 60'(sd3_reg.mag[i]) * 60'(sd3_reg.mag[i]);
            sd4_reg  <= sd3_reg;
            sum5_reg <= 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
            sd5_reg  <= sd4_reg;
        end
    end

    // square root, one result bit per stage
    sq_t  sq_reg [lab_pkg::SQRT_STEPS+1];
    logic sv_reg [lab_pkg::SQRT_STEPS+1];

    always_comb
    begin
        sq_reg[0].n  = sum5_reg;
        sq_reg[0].r  = 63'd0;
        sq_reg[0].sd = sd5_reg;
        sv_reg[0]    = v5_reg;
    end

    for (genvar i = 0; i < lab_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        localparam logic [62:0] BITV = 63'(1) << (2 * (lab_pkg::SQRT_STEPS - 1 - i));
        logic [62:0] trial;
        sq_t         st_next;

        always_comb
        begin
            trial   = sq_reg[i].r + BITV;
            st_next = sq_reg[i];
            if ({1'b0, sq_reg[i].n} >= trial)
            begin
                st_next.n = 62'({1'b0, sq_reg[i].n} - trial);
                st_next.r = (sq_reg[i].r >> 1) + BITV;
            end
            else
                st_next.r = sq_reg[i].r >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[i+1] <= 1'b0;
            else if (en)
                sv_reg[i+1] <= sv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[i+1] <= st_next;
        end
    end

    // divider setup: mag * one + len / 2
    dv_t  dv_reg [lab_pkg::DIV_STEPS+1];
    logic dvv_reg [lab_pkg::DIV_STEPS+1];
    dv_t  prep_next;

    always_comb
    begin
        logic [30:0] len;
        len = sq_reg[lab_pkg::SQRT_STEPS].r[30:0];
        for (int i = 0; i < 3; i++)
        begin
            prep_next.rem[i] = 45'({sq_reg[lab_pkg::SQRT_STEPS].sd.mag[i], 14'd0})
                               + 45'(len >> 1);
            prep_next.q[i]   = 15'd0;
        end
        prep_next.den = len;
        prep_next.neg = sq_reg[lab_pkg::SQRT_STEPS].sd.neg;
        prep_next.ok  = sq_reg[lab_pkg::SQRT_STEPS].sd.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvv_reg[0] <= 1'b0;
        else if (en)
            dvv_reg[0] <= sv_reg[lab_pkg::SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= prep_next;
    end

    for (genvar j = 0; j < lab_pkg::DIV_STEPS; j++)
    begin : g_div
        localparam int K = lab_pkg::DIV_STEPS - 1 - j;
        dv_t dv_next;

        always_comb
        begin
            logic [44:0] dsh;
            dv_next = dv_reg[j];
            dsh = 45'(dv_reg[j].den) << K;
            for (int i = 0; i < 3; i++)
                if (dv_reg[j].rem[i] >= dsh)
                begin
                    dv_next.rem[i]  = dv_reg[j].rem[i] - dsh;
                    dv_next.q[i][K] = 1'b1;
                end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvv_reg[j+1] <= 1'b0;
            else if (en)
                dvv_reg[j+1] <= dvv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[j+1] <= dv_next;
        end
    end

    // cap, sign, zero on degenerate
    logic            fv_reg;
    lab_pkg::vec16_t fo_reg;
    logic            fok_reg;
    logic [2:0][15:0] fin_next;

    always_comb
    begin
        logic [15:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = (16'(dv_reg[lab_pkg::DIV_STEPS].q[i]) > lab_pkg::Q_ONE) ? lab_pkg::Q_ONE
                : 16'(dv_reg[lab_pkg::DIV_STEPS].q[i]);
            if (!dv_reg[lab_pkg::DIV_STEPS].ok)
                fin_next[i] = 16'd0;
            else
                fin_next[i] = dv_reg[lab_pkg::DIV_STEPS].neg[i] ? 16'(-c) : c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (en)
            fv_reg <= dvv_reg[lab_pkg::DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fo_reg.x <= fin_next[0];
            fo_reg.y <= fin_next[1];
            fo_reg.z <= fin_next[2];
            fok_reg  <= dv_reg[lab_pkg::DIV_STEPS].ok;
        end
    end

    assign out_valid = fv_reg;
    assign out_vec   = fo_reg;
    assign out_ok    = fok_reg;

endmodule

### src/look_at_basis.sv
// Look-at camera basis. Each item carries a camera position and a target point
// (signed Q16.16); each result gives the right, up and forward axes in signed
// Q2.14 (16384 = 1.0) plus a degenerate flag, set with all axes zero when the
// position equals the target or forward is parallel to world up. One item is
// accepted per clock while the output is not stalled; results leave in input
// order through the two normalizers, each a 31-stage square root
// followed by a 15-stage restoring divider. The whole pipeline holds while the
// output item is stalled.
module look_at_basis (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, target_x, target_y, target_z
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z
    output logic [143:0] m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);

    localparam int LAT = lab_pkg::NORM_LAT;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input stage: exact difference
    logic            v0_reg;
    lab_pkg::vec33_t d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg.x <= 33'($signed(s_axis_tdata[31:0]))   - 33'($signed(s_axis_tdata[127:96]));
            d_reg.y <= 33'($signed(s_axis_tdata[63:32]))  - 33'($signed(s_axis_tdata[159:128]));
            d_reg.z <= 33'($signed(s_axis_tdata[95:64]))  - 33'($signed(s_axis_tdata[191:160]));
        end
    end

    logic            fv;
    lab_pkg::vec16_t fwd;
    logic            fok;

    lab_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_vec    (d_reg),
        .out_valid (fv),
        .out_vec   (fwd),
        .out_ok    (fok)
    );

    lab_pkg::vec33_t rv;
    always_comb
    begin
        rv.x = 33'(fwd.z);
        rv.y = 33'sd0;
        rv.z = 33'(-33'(fwd.x));
    end

    logic            rvld;
    lab_pkg::vec16_t rgt;
    logic            rok;

    lab_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv),
        .in_vec    (rv),
        .out_valid (rvld),
        .out_vec   (rgt),
        .out_ok    (rok)
    );

    // hold forward alongside the second normalizer
    lab_pkg::vec16_t fd_reg [LAT];
    logic            okd_reg [LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fd_reg[0]  <= fwd;
            okd_reg[0] <= fok;
            for (int i = 1; i < LAT; i++)
            begin
                fd_reg[i]  <= fd_reg[i-1];
                okd_reg[i] <= okd_reg[i-1];
            end
        end
    end

    // cross product, right_y is always zero
    logic                v1_reg;
    logic signed [31:0]  p0_reg, p1a_reg, p1b_reg, p2_reg;
    lab_pkg::vec16_t     f1_reg, r1_reg;
    logic                ok1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= rvld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= 32'(fd_reg[LAT-1].y) * 32'(rgt.z);
            p1a_reg <= 32'(fd_reg[LAT-1].z) * 32'(rgt.x);
            p1b_reg <= 32'(fd_reg[LAT-1].x) * 32'(rgt.z);
            p2_reg  <= 32'(fd_reg[LAT-1].y) * 32'(rgt.x);
            f1_reg  <= fd_reg[LAT-1];
            r1_reg  <= rgt;
            ok1_reg <= rok && okd_reg[LAT-1];
        end
    end

    logic            ov_reg;
    lab_pkg::vec16_t or_reg, ou_reg, of_reg;
    logic            odeg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            odeg_reg <= !ok1_reg;
            if (ok1_reg)
            begin
                or_reg   <= r1_reg;
                of_reg   <= f1_reg;
                ou_reg.x <= lab_pkg::rnd_q28(34'(p0_reg));
                ou_reg.y <= lab_pkg::rnd_q28(34'(p1a_reg) - 34'(p1b_reg));
                ou_reg.z <= lab_pkg::rnd_q28(34'sd0 - 34'(p2_reg));
            end
            else
            begin
                or_reg <= '0;
                of_reg <= '0;
                ou_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {of_reg.z, of_reg.y, of_reg.x,
                            ou_reg.z, ou_reg.y, ou_reg.x,
                            or_reg.z, or_reg.y, or_reg.x};
    assign m_axis_tuser  = odeg_reg;

endmodule
